>>> rtl/string_escape_decoder_top_defines.svh
// Assertion macros shared by the escape decoder RTL.
`ifndef STRING_ESCAPE_DECODER_TOP_DEFINES_SVH
`define STRING_ESCAPE_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define SED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escape decoder check failed");
// Next-cycle implication, checked outside reset.
`define SED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escape decoder check failed");
`else
`define SED_ASSERT_NOW(lbl, ante, cons)
`define SED_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/sed_pkg.sv
package sed_pkg;

  // Command queue between the classifier and the byte sequencer.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  // Positions in the pending mask of one command.
  localparam int unsigned PEND_B3 = 3;
  localparam int unsigned PEND_B2 = 2;
  localparam int unsigned PEND_B1 = 1;
  localparam int unsigned PEND_B0 = 0;
  localparam int unsigned PEND_CHR = 4;
  localparam int unsigned PEND_END = 5;
  localparam int unsigned PEND_W = 6;

  // One classified input byte: a run value to flush, an optional character
  // and an end marker, each enabled by a bit of the pending mask.
  typedef struct packed {
    logic [31:0]       value;
    logic [7:0]        chr;
    logic [PEND_W-1:0] pend;
    logic              last;
  } sed_cmd_t;

endpackage

>>> rtl/string_escape_decoder_top.sv
// Backslash escape decoder for the text of a string literal.
// Input channel: in_byte_i/in_last_i with in_valid_i and in_stall_o; one byte
// per transaction, in_last_i on the final byte of the literal.
// Output channel: out_byte_o/out_byte_valid_o/out_last_o with out_valid_o and
// out_stall_i; one decoded byte or a bare end marker per transaction.
// Each input byte gives zero to five results. A classifier takes one byte per
// cycle unless the queue is full and queues a command (up to four run bytes,
// one character, an end marker); a sequencer gives one result per cycle from
// the queue head unless the receiver stalls. Commands are registered in the
// queue, results in the output register. Throughput is one byte per cycle
// while each byte gives at most one result; a byte with k results holds the
// sequencer; the four-entry queue absorbs bursts before in_stall_o rises.
// When the receiver stalls, the held result stays on the outputs and the
// queue fills; the input side stalls only once the queue is full.
// Reset clears the decoder to plain text mode and empties the queue and the
// output register.
`include "string_escape_decoder_top_defines.svh"

module string_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_byte_valid_o,
  output logic       out_last_o
);

  logic                     accept;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_empty;
  logic                     q_full;
  logic [sed_pkg::QCW-1:0]  q_count;
  sed_pkg::sed_cmd_t        cmd;
  sed_pkg::sed_cmd_t        head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Classifier: mode tracking and digit accumulation.
  sed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (q_push),
    .cmd_o     (cmd)
  );

  // Command queue.
  sed_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (cmd),
    .pop_i      (q_pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full),
    .count_o    (q_count)
  );

  // Sequencer and output register.
  sed_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .out_byte_valid_o (out_byte_valid_o),
    .out_last_o       (out_last_o)
  );

  // The sequencer never pops an empty queue.
  `SED_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)
  // Every queued command carries at least one result.
  `SED_ASSERT_NOW(a_push_has_work, q_push, cmd.pend != '0)
  // A bare end marker is always the final result and carries a zero byte.
  `SED_ASSERT_NOW(a_marker_is_last, out_valid_o && !out_byte_valid_o,
                  out_last_o && (out_byte_o == 8'h00))
  // A push into a full queue would be lost; a push and no pop grows the count.
  `SED_ASSERT_NEXT(a_count_grows, q_push && !q_pop && !q_full,
                   q_count == $past(q_count) + 1'b1)

endmodule

>>> rtl/sed_front.sv
module sed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              push_o,
  output sed_pkg::sed_cmd_t cmd_o
);

  // Decoder mode, one-hot.
  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_BIN   = 5'b00100,
    MODE_OCT   = 5'b01000,
    MODE_HEX   = 5'b10000
  } mode_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LO     = 8'h6F;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;

  localparam logic [7:0] CTL_NL  = 8'h0A;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_BEL = 8'h07;

  localparam logic [5:0] LIMIT_BIN = 6'd32;
  localparam logic [5:0] LIMIT_OCT = 6'd10;
  localparam logic [5:0] LIMIT_HEX = 6'd8;

  // Digit value in the radix of the mode; bit 4 set means not a digit.
  function automatic logic [4:0] digit_value(input logic [7:0] b, input mode_e m);
    logic [4:0] d;
    d = 5'h10;
    unique case (m)
      MODE_BIN: begin
        if (b == CH_ZERO || b == CH_ONE) d = {1'b0, b[3:0]};
      end
      MODE_OCT: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) d = {1'b0, b[3:0]};
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) d = {1'b0, b[3:0]};
        else if ((b >= CH_UA && b <= CH_UF) || (b >= CH_LA && b <= CH_LF))
          d = {1'b0, b[3:0] + 4'd9};
      end
    endcase
    return d;
  endfunction

  mode_e       mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [4:0]  dig;
  logic [31:0] acc_sh;
  logic [31:0] acc_n;
  logic [5:0]  cnt_n;
  logic [5:0]  limit;
  logic        flush;
  logic [31:0] flush_val;
  logic        chr_v;
  logic [7:0]  chr;
  logic [3:0]  nz;
  logic        run_after;

  // Shift-add of the digit run.
  always_comb begin
    dig = digit_value(in_byte_i, mode_q);
    unique case (mode_q)
      MODE_BIN: begin
        acc_sh = {acc_q[30:0], 1'b0};
        limit  = LIMIT_BIN;
      end
      MODE_OCT: begin
        acc_sh = {acc_q[28:0], 3'b000};
        limit  = LIMIT_OCT;
      end
      default: begin
        acc_sh = {acc_q[27:0], 4'b0000};
        limit  = LIMIT_HEX;
      end
    endcase
    acc_n = acc_sh + {28'd0, dig[3:0]};
    cnt_n = cnt_q + 6'd1;
  end

  // Classify the byte and compute the next mode.
  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    flush     = 1'b0;
    flush_val = acc_q;
    chr_v     = 1'b0;
    chr       = in_byte_i;
    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        acc_d  = '0;
        cnt_d  = '0;
        unique case (in_byte_i)
          CH_ZERO: chr_v = 1'b0;
          CH_LN: begin
            chr_v = 1'b1;
            chr   = CTL_NL;
          end
          CH_LT: begin
            chr_v = 1'b1;
            chr   = CTL_TAB;
          end
          CH_LR: begin
            chr_v = 1'b1;
            chr   = CTL_CR;
          end
          CH_LF: begin
            chr_v = 1'b1;
            chr   = CTL_FF;
          end
          CH_LV: begin
            chr_v = 1'b1;
            chr   = CTL_VT;
          end
          CH_LB: begin
            chr_v = 1'b1;
            chr   = CTL_BS;
          end
          CH_LA: begin
            chr_v = 1'b1;
            chr   = CTL_BEL;
          end
          CH_UB: mode_d = MODE_BIN;
          CH_LO: mode_d = MODE_OCT;
          CH_LX, CH_LU: mode_d = MODE_HEX;
          default: chr_v = 1'b1;
        endcase
      end
      MODE_BIN, MODE_OCT, MODE_HEX: begin
        if (!dig[4]) begin
          acc_d = acc_n;
          cnt_d = cnt_n;
          if (cnt_n >= limit) begin
            flush     = 1'b1;
            flush_val = acc_n;
            mode_d    = MODE_PLAIN;
            acc_d     = '0;
            cnt_d     = '0;
          end
        end else begin
          // A non-digit ends the run; a backslash then opens an escape, any other byte is plain text.
          flush = 1'b1;
          acc_d = '0;
          cnt_d = '0;
          if (in_byte_i == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            mode_d = MODE_PLAIN;
            chr_v  = 1'b1;
          end
        end
      end
      default: begin
        if (in_byte_i == CH_BSLASH) mode_d = MODE_ESC;
        else chr_v = 1'b1;
      end
    endcase

    // The final byte flushes a pending run and returns to reset state.
    run_after = (mode_d == MODE_BIN) || (mode_d == MODE_OCT) || (mode_d == MODE_HEX);
    if (in_last_i) begin
      if (run_after) begin
        flush     = 1'b1;
        flush_val = acc_d;
      end
      mode_d = MODE_PLAIN;
      acc_d  = '0;
      cnt_d  = '0;
    end
  end

  // Build the command for the sequencer.
  always_comb begin
    nz = {|flush_val[31:24], |flush_val[23:16], |flush_val[15:8], |flush_val[7:0]};
    cmd_o.value = flush_val;
    cmd_o.chr   = chr;
    cmd_o.last  = in_last_i;
    cmd_o.pend[sed_pkg::PEND_B3] = flush & nz[3];
    cmd_o.pend[sed_pkg::PEND_B2] = flush & nz[2];
    cmd_o.pend[sed_pkg::PEND_B1] = flush & nz[1];
    cmd_o.pend[sed_pkg::PEND_B0] = flush & nz[0];
    cmd_o.pend[sed_pkg::PEND_CHR] = chr_v;
    cmd_o.pend[sed_pkg::PEND_END] = in_last_i && !(chr_v || (flush && (|nz)));
  end

  assign push_o = accept_i && (|cmd_o.pend);

  // Mode and run state advance once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> rtl/sed_queue.sv
module sed_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  sed_pkg::sed_cmd_t        push_cmd_i,
  input  logic                     pop_i,
  output sed_pkg::sed_cmd_t        head_o,
  output logic                     empty_o,
  output logic                     full_o,
  output logic [sed_pkg::QCW-1:0]  count_o
);

  sed_pkg::sed_cmd_t             mem_q [sed_pkg::QDEPTH];
  logic [sed_pkg::QAW-1:0]       wptr_q, rptr_q;
  logic [sed_pkg::QCW-1:0]       cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == sed_pkg::QCW'(sed_pkg::QDEPTH));
  assign head_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  // Storage; no reset needed for payload.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_cmd_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/sed_back.sv
module sed_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sed_pkg::sed_cmd_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              out_byte_valid_o,
  output logic              out_last_o
);

  logic [sed_pkg::PEND_W-1:0] done_q, done_d;
  logic [sed_pkg::PEND_W-1:0] rem;
  logic [sed_pkg::PEND_W-1:0] sel;
  logic [7:0]                 byte_sel;
  logic                       is_final;
  logic                       advance;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_bv_q;
  logic       out_last_q;

  // Pick the next result of the head command, high run byte first.
  always_comb begin
    rem      = head_i.pend & ~done_q;
    sel      = '0;
    byte_sel = '0;
    priority if (rem[sed_pkg::PEND_B3]) begin
      sel[sed_pkg::PEND_B3] = 1'b1;
      byte_sel = head_i.value[31:24];
    end else if (rem[sed_pkg::PEND_B2]) begin
      sel[sed_pkg::PEND_B2] = 1'b1;
      byte_sel = head_i.value[23:16];
    end else if (rem[sed_pkg::PEND_B1]) begin
      sel[sed_pkg::PEND_B1] = 1'b1;
      byte_sel = head_i.value[15:8];
    end else if (rem[sed_pkg::PEND_B0]) begin
      sel[sed_pkg::PEND_B0] = 1'b1;
      byte_sel = head_i.value[7:0];
    end else if (rem[sed_pkg::PEND_CHR]) begin
      sel[sed_pkg::PEND_CHR] = 1'b1;
      byte_sel = head_i.chr;
    end else begin
      sel[sed_pkg::PEND_END] = 1'b1;
    end
    is_final = ((rem & ~sel) == '0);
  end

  // A free or drained output register takes the next result of a queued command.
  assign advance     = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = advance && is_final;
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_comb begin
    done_d = done_q;
    if (advance) done_d = is_final ? '0 : (done_q | sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_sel;
      out_bv_q   <= !sel[sed_pkg::PEND_END];
      out_last_q <= head_i.last && is_final;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_bv_q;
  assign out_last_o       = out_last_q;

endmodule
